### hdl/lhe_pkg.sv
// ----------------------------------------------------------------------------
// lhe_pkg
// Shared types for the luma histogram equalizer: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package lhe_pkg;

   localparam int unsigned PIX_W = 8;   // luma sample and table entry width
   localparam int unsigned Q_W   = 8;   // quotient bits of one table entry

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APPLY,
      ST_GATHER,
      ST_BREAD,
      ST_BACC,
      ST_BMUL,
      ST_BDIV,
      ST_BWRITE
   } state_type;

   typedef struct packed {
      logic clr_step;    // write zero bin and identity entry at index, advance
      logic latch;       // capture clamped pixel of accepted transaction
      logic gather_wr;   // write incremented bin, bump frame total
      logic cum_clr;     // zero running sum before a build
      logic bld_acc;     // add bin to running sum, clear that bin
      logic bld_mul;     // scale running sum by top level
      logic div_step;    // one quotient bit
      logic bld_wr;      // write table entry, advance index
      logic total_clr;   // zero frame total
      logic out_load;    // capture table read into result register
   } cmd_type;

   typedef struct packed {
      logic idx_last;    // index sits on the top level
      logic div_last;    // final quotient bit in progress
   } status_type;

endpackage

### hdl/lhe_ram.sv
// ----------------------------------------------------------------------------
// lhe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhe_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lhe_ctrl.sv
// ----------------------------------------------------------------------------
// lhe_ctrl
// Controller: sequences clearing pass, gather, apply and table build, and
// owns the input and result handshakes.
// ----------------------------------------------------------------------------
module lhe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_kind,
   input  logic                in_last,
   output logic                out_valid,
   input  logic                out_ready,
   output lhe_pkg::cmd_type    cmd,
   input  lhe_pkg::status_type sts
);
   import lhe_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      last_ff, last_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
      end
   end

   assign in_ready  = (state_ff == ST_IDLE) && (!out_valid_ff || out_ready);
   assign accept    = in_valid && in_ready;
   assign out_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !out_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step  = 1'b1;
            cmd.total_clr = 1'b1;
            if (sts.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               last_in   = in_last;
               state_in  = in_kind ? ST_APPLY : ST_GATHER;
            end
         end
         ST_APPLY: begin
            cmd.out_load = 1'b1;
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_GATHER: begin
            cmd.gather_wr = 1'b1;
            cmd.cum_clr   = 1'b1;
            state_in      = last_ff ? ST_BREAD : ST_IDLE;
         end
         ST_BREAD: begin
            state_in = ST_BACC;
         end
         ST_BACC: begin
            cmd.bld_acc = 1'b1;
            state_in    = ST_BMUL;
         end
         ST_BMUL: begin
            cmd.bld_mul = 1'b1;
            state_in    = ST_BDIV;
         end
         ST_BDIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_BWRITE;
            end
         end
         ST_BWRITE: begin
            cmd.bld_wr = 1'b1;
            if (sts.idx_last) begin
               cmd.total_clr = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_BREAD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

### hdl/lhe_datapath.sv
// ----------------------------------------------------------------------------
// lhe_datapath
// Datapath: histogram and transfer table memories, frame total, running sum,
// scaling multiply, bit-serial divider and result register.
// ----------------------------------------------------------------------------
module lhe_datapath #(
   parameter int unsigned LEVELS     = 256,
   parameter int unsigned MAX_PIXELS = 1048576
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lhe_pkg::PIX_W-1:0]   in_pixel,
   input  lhe_pkg::cmd_type            cmd,
   output lhe_pkg::status_type         sts,
   output logic [lhe_pkg::PIX_W-1:0]   out_pixel
);
   import lhe_pkg::*;

   localparam int unsigned LW = $clog2(LEVELS);
   localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
   localparam int unsigned PW = CW + PIX_W;
   localparam logic [LW-1:0] TOP_LEVEL = LW'(LEVELS - 1);
   localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_PIXELS);
   localparam logic [PIX_W-1:0] SCALE  = PIX_W'(LEVELS - 1);

   logic [LW-1:0]    pix_clamp;
   logic [LW-1:0]    pix_ff;
   logic [LW-1:0]    idx_ff;
   logic [CW-1:0]    total_ff;
   logic [CW-1:0]    cum_ff;
   logic [PW-1:0]    rem_ff;
   logic [Q_W-1:0]   q_ff;
   logic [2:0]       cnt_ff;
   logic [PIX_W-1:0] out_ff;

   logic             bin_we;
   logic [LW-1:0]    bin_waddr, bin_raddr;
   logic [CW-1:0]    bin_wdata, bin_rdata;
   logic             tab_we;
   logic [PIX_W-1:0] tab_wdata, tab_rdata;
   logic [CW:0]      cum_sum;
   logic [PW-1:0]    trial;

   assign pix_clamp = (in_pixel > SCALE) ? TOP_LEVEL : in_pixel[LW-1:0];
   assign bin_raddr = cmd.latch ? pix_clamp : idx_ff;

   always_comb begin
      bin_we    = cmd.clr_step || cmd.gather_wr || cmd.bld_acc;
      bin_waddr = cmd.gather_wr ? pix_ff : idx_ff;
      bin_wdata = '0;
      if (cmd.gather_wr && (bin_rdata < CNT_MAX)) begin
         bin_wdata = bin_rdata + CW'(1);
      end else if (cmd.gather_wr) begin
         bin_wdata = bin_rdata;
      end
      tab_we    = cmd.clr_step || cmd.bld_wr;
      tab_wdata = cmd.clr_step ? PIX_W'(idx_ff) : q_ff;
   end

   lhe_ram #(.WIDTH(CW), .DEPTH(LEVELS)) u_bins (
      .clock  (clock),
      .wr_en  (bin_we),
      .wr_addr(bin_waddr),
      .wr_data(bin_wdata),
      .rd_addr(bin_raddr),
      .rd_data(bin_rdata)
   );

   lhe_ram #(.WIDTH(PIX_W), .DEPTH(LEVELS)) u_table (
      .clock  (clock),
      .wr_en  (tab_we),
      .wr_addr(idx_ff),
      .wr_data(tab_wdata),
      .rd_addr(pix_clamp),
      .rd_data(tab_rdata)
   );

   assign cum_sum = {1'b0, cum_ff} + {1'b0, bin_rdata};
   assign trial   = PW'(total_ff) << (3'd7 - cnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         pix_ff <= pix_clamp;
      end
      // index wraps to zero after the top level, ready for the next sweep
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.clr_step || cmd.bld_wr) begin
         idx_ff <= (idx_ff == TOP_LEVEL) ? '0 : idx_ff + LW'(1);
      end
      if (cmd.total_clr) begin
         total_ff <= '0;
      end else if (cmd.gather_wr && (total_ff < CNT_MAX)) begin
         total_ff <= total_ff + CW'(1);
      end
      if (cmd.cum_clr) begin
         cum_ff <= '0;
      end else if (cmd.bld_acc) begin
         // saturated bins can overshoot the total: clamp
         cum_ff <= (cum_sum > {1'b0, total_ff}) ? total_ff : cum_sum[CW-1:0];
      end
      if (cmd.bld_mul) begin
         rem_ff <= PW'(cum_ff) * PW'(SCALE);
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            q_ff   <= q_ff | (Q_W'(1) << (3'd7 - cnt_ff));
         end
         cnt_ff <= cnt_ff + 3'd1;
      end
      if (cmd.out_load) begin
         out_ff <= tab_rdata;
      end
   end

   assign sts.idx_last = (idx_ff == TOP_LEVEL);
   assign sts.div_last = (cnt_ff == 3'd7);
   assign out_pixel    = out_ff;

endmodule

### hdl/luma_histogram_equalizer_unit.sv
// ----------------------------------------------------------------------------
// luma_histogram_equalizer_unit
// Histogram equalization of 8-bit luma: gathers a histogram per frame,
// builds a transfer table on the last pixel and maps pixels through it.
// ----------------------------------------------------------------------------
//   channel | direction | tdata         | tuser | tlast
//   req_    | in        | pixel [7:0]   | kind  | last
//   rsp_    | out       | mapped_pixel  | -     | -
//
// Apply: the table read, then the result register, lie between transaction
// and result; gather: the bin read, then the bin write-back.
// Frame end: table build steps through every level (read, sum, multiply,
// 8-step divider, write). After reset a clearing pass zeroes all LEVELS
// bins and loads the identity table; no transaction is taken meanwhile.
// A full result register stalls input until rsp_tready takes it.
// ----------------------------------------------------------------------------
module luma_histogram_equalizer_unit #(
   parameter int unsigned LEVELS     = 256,
   parameter int unsigned MAX_PIXELS = 1048576
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pixel
   input  logic       req_tuser,   // [0] kind
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [7:0] mapped_pixel
);
   import lhe_pkg::*;

   cmd_type    cmd;
   status_type sts;

   lhe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_last  (req_tlast),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .cmd      (cmd),
      .sts      (sts)
   );

   lhe_datapath #(.LEVELS(LEVELS), .MAX_PIXELS(MAX_PIXELS)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .in_pixel (req_tdata),
      .cmd      (cmd),
      .sts      (sts),
      .out_pixel(rsp_tdata)
   );

   a_apply_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> ##1 rsp_tvalid)
      else $error("apply transaction produced no result");

   a_gather_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !req_tready)
      else $error("input taken during gather update");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("input taken while result register blocked");

endmodule
